FILE: rtl/core/gtg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the go-to-goal steering pipeline.
// ---------------------------------------------------------------------------
package gtg_pkg;

	localparam int CordicStages = 16;
	localparam int SqrtSteps = 17;
	localparam int Depth = (CordicStages > SqrtSteps) ? CordicStages : SqrtSteps;

	localparam logic signed [33:0] PiQ30 = 34'sd3373259426;
	localparam logic signed [16:0] PiQ12 = 17'sd12868;
	localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
	localparam logic [18:0] LinMax = 19'd278528;
	localparam logic signed [16:0] AngMax = 17'sd51472;

	localparam logic [2:0] REG_TOL = 3'd0;
	localparam logic [2:0] REG_CAP = 3'd1;
	localparam logic [2:0] REG_TGAIN = 3'd2;
	localparam logic [2:0] REG_SGAIN = 3'd3;
	localparam logic [2:0] REG_AGAIN = 3'd4;

	function automatic logic signed [33:0] atan_q30(input int i);
		case (i)
			0: atan_q30 = 34'sd843314857;
			1: atan_q30 = 34'sd497837829;
			2: atan_q30 = 34'sd263043837;
			3: atan_q30 = 34'sd133525159;
			4: atan_q30 = 34'sd67021687;
			5: atan_q30 = 34'sd33543516;
			6: atan_q30 = 34'sd16775851;
			7: atan_q30 = 34'sd8388437;
			8: atan_q30 = 34'sd4194283;
			9: atan_q30 = 34'sd2097149;
			10: atan_q30 = 34'sd1048576;
			11: atan_q30 = 34'sd524288;
			12: atan_q30 = 34'sd262144;
			13: atan_q30 = 34'sd131072;
			14: atan_q30 = 34'sd65536;
			15: atan_q30 = 34'sd32768;
			16: atan_q30 = 34'sd16384;
			17: atan_q30 = 34'sd8192;
			18: atan_q30 = 34'sd4096;
			19: atan_q30 = 34'sd2048;
			20: atan_q30 = 34'sd1024;
			21: atan_q30 = 34'sd512;
			22: atan_q30 = 34'sd256;
			23: atan_q30 = 34'sd128;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction

	// One item as it travels down the row of cells.
	typedef struct packed {
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic signed [33:0] z;
		logic [33:0] rem;
		logic [16:0] root;
		logic [33:0] sq;
		logic signed [14:0] hd;
	} cell_t;

endpackage

FILE: rtl/core/go_to_goal_steering.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// go_to_goal_steering
// Proportional go-to-goal controller: distance and bearing to a goal
// turned into linear and angular speed commands.
// ---------------------------------------------------------------------------
// Usage: poses enter on the s_axis channel, one command leaves on m_axis
// for each pose. A plain write port (cfg_we, cfg_idx, cfg_data) sets the
// tolerance, capture radius and three gains; write it only while idle.
// One item is accepted every cycle while the output is not stalled. The
// accepting edge loads the entry stage; the item then passes a row of 17
// cells (each one square-root digit, the first 16 also one CORDIC
// micro-rotation) and three output stages (bearing error and wrap, gain
// multiply, then rounding and saturation) before it is valid at the output.
// The whole row advances together; when the receiver stalls with a full
// output register, the row holds and s_axis_tready falls, so nothing is
// lost. Bubbles travel with the row: it advances whenever the output
// register is empty or being taken. Reset clears all valid flags and loads
// the register defaults.
// ---------------------------------------------------------------------------
module go_to_goal_steering (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// robot_x[15:0], robot_y[31:16], robot_heading[46:32], goal_x[62:47],
	// goal_y[78:63], zeros[79]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// linear_speed[18:0], angular_speed[35:19], goal_reached[36], turning[37],
	// zeros[39:38]
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	localparam int N = gtg_pkg::Depth;

	logic [13:0] tol_q;
	logic [15:0] cap_q, tgain_q, sgain_q, again_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 14'd205;
			cap_q <= 16'd2048;
			tgain_q <= 16'd410;
			sgain_q <= 16'd12288;
			again_q <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_idx)
				gtg_pkg::REG_TOL: tol_q <= cfg_data[13:0];
				gtg_pkg::REG_CAP: cap_q <= cfg_data;
				gtg_pkg::REG_TGAIN: tgain_q <= cfg_data;
				gtg_pkg::REG_SGAIN: sgain_q <= cfg_data;
				gtg_pkg::REG_AGAIN: again_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: everything advances when the output slot frees
	logic adv;
	logic v_s1, v_s2, v_out_q;
	logic v_c [N+1];
	gtg_pkg::cell_t d_c [N+1];

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// entry stage: offsets, fold, squared length
	logic signed [16:0] dx, dy;
	logic signed [14:0] hd_in;
	gtg_pkg::cell_t ent;
	always_comb begin
		dx = $signed({1'b0, s_axis_tdata[62:47]}) - $signed({1'b0, s_axis_tdata[15:0]});
		dy = $signed({1'b0, s_axis_tdata[78:63]}) - $signed({1'b0, s_axis_tdata[31:16]});
		hd_in = s_axis_tdata[46:32];
		ent = '0;
		ent.hd = hd_in;
		ent.x = {{2{dx[16]}}, dx, 12'd0};
		ent.y = {{2{dy[16]}}, dy, 12'd0};
		if (dx < 0) begin
			ent.z = (dy >= 0) ? gtg_pkg::PiQ30 : -gtg_pkg::PiQ30;
			ent.x = -ent.x;
			ent.y = -ent.y;
		end
		ent.sq = 34'(dx * dx) + 34'(dy * dy);
	end

	logic zero_c [N+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (adv) begin
			v_c[0] <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			d_c[0] <= ent;
			zero_c[0] <= (dx == 17'sd0) && (dy == 17'sd0);
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_row
		gtg_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .idx(5'(g)),
			.v_in(v_c[g]), .d_in(d_c[g]), .v_out(v_c[g+1]), .d_out(d_c[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				zero_c[g+1] <= zero_c[g];
			end
		end
	end

	// finish: round bearing, error, wrap, compare against tolerance
	gtg_pkg::cell_t t;
	logic [16:0] dist_len;
	logic [17:0] rr;
	logic signed [33:0] zr;
	logic signed [16:0] brg, err;
	logic [16:0] mag;
	logic turn;
	always_comb begin
		t = d_c[N];
		rr = {t.root, 1'b0};
		dist_len = t.root + ((t.rem > 34'(t.root)) ? 17'd1 : 17'd0);
		zr = (t.z + 34'sd131072) >>> 18;
		brg = zero_c[N] ? 17'sd0 : zr[16:0];
		err = brg - 17'(t.hd);
		if (err > gtg_pkg::PiQ12) err = err - gtg_pkg::TwoPiQ12;
		else if (err < -gtg_pkg::PiQ12) err = err + gtg_pkg::TwoPiQ12;
		mag = (err < 0) ? 17'(-err) : 17'(err);
		turn = mag > {3'd0, tol_q};
	end

	logic [16:0] dist_s1;
	logic signed [16:0] err_s1;
	logic gr_s1, turn_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_c[N];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s1 <= dist_len;
			err_s1 <= err;
			gr_s1 <= dist_len < {1'b0, cap_q};
			turn_s1 <= turn;
		end
	end

	// choose gain and multiply
	logic [32:0] lin_s2;
	logic signed [33:0] ang_s2;
	logic gr_s2, turn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s2 <= 33'(dist_s1) * 33'(turn_s1 ? tgain_q : sgain_q);
			ang_s2 <= 34'(err_s1) * $signed({18'd0, again_q});
			gr_s2 <= gr_s1;
			turn_s2 <= turn_s1;
		end
	end

	logic [20:0] lr;
	logic signed [21:0] ar;
	logic [18:0] lin_o;
	logic signed [16:0] ang_o;
	always_comb begin
		lr = 21'((lin_s2 + 33'd2048) >> 12);
		ar = 22'((ang_s2 + 34'sd2048) >>> 12);
		lin_o = (lr > 21'(gtg_pkg::LinMax)) ? gtg_pkg::LinMax : lr[18:0];
		if (!turn_s2) ang_o = 17'sd0;
		else if (ar > 22'(gtg_pkg::AngMax)) ang_o = gtg_pkg::AngMax;
		else if (ar < -22'(gtg_pkg::AngMax)) ang_o = -gtg_pkg::AngMax;
		else ang_o = ar[16:0];
	end

	logic [39:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (adv) begin
			v_out_q <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {2'b00, turn_s2, gr_s2, ang_o, lin_o};
		end
	end

	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata = out_q;

	logic unused;
	assign unused = ^rr;

endmodule

FILE: rtl/core/gtg_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gtg_cell
// One step of the row: one square-root digit, and in the first 16 cells one CORDIC micro-rotation.
// ---------------------------------------------------------------------------
module gtg_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [4:0]           idx,
	input  logic                 v_in,
	input  gtg_pkg::cell_t       d_in,
	output logic                 v_out,
	output gtg_pkg::cell_t       d_out
);

	gtg_pkg::cell_t nx;
	logic [4:0] sh;
	logic [5:0] rb;
	logic [33:0] trial;

	always_comb begin
		nx = d_in;
		sh = idx;
		if (32'(idx) < gtg_pkg::CordicStages) begin
			if (d_in.y >= 0) begin
				nx.x = d_in.x + (d_in.y >>> sh);
				nx.y = d_in.y - (d_in.x >>> sh);
				nx.z = d_in.z + gtg_pkg::atan_q30(32'(idx));
			end else begin
				nx.x = d_in.x - (d_in.y >>> sh);
				nx.y = d_in.y + (d_in.x >>> sh);
				nx.z = d_in.z - gtg_pkg::atan_q30(32'(idx));
			end
		end
		// restoring sqrt: bring in two bits of sq per cell, MSB first
		trial = 34'd0;
		rb = 6'd0;
		if (32'(idx) < gtg_pkg::SqrtSteps) begin
			rb = 6'(2 * (gtg_pkg::SqrtSteps - 1 - 32'(idx)));
			nx.rem = {d_in.rem[31:0], 2'(d_in.sq >> rb)};
			trial = {15'd0, d_in.root, 2'b01};
			nx.root = {d_in.root[15:0], 1'b0};
			if (nx.rem >= trial) begin
				nx.rem = nx.rem - trial;
				nx.root[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nx;
		end
	end

endmodule
